// File: hdl/snfcs_pkg.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer package
// Shared types, command bytes and sizing constants.
// ----------------------------------------------------------------------------
package snfcs_pkg;

    // Request function codes
    typedef enum logic [2:0] {
        FN_READ   = 3'd0,
        FN_PROG   = 3'd1,
        FN_ERASE  = 3'd2,
        FN_ID     = 3'd3,
        FN_RSTAT  = 3'd4,
        FN_WSTAT  = 3'd5,
        FN_WEN    = 3'd6
    } t_func;

    // Frame kinds seen by the serial shifter
    typedef enum logic [1:0] {
        FK_WRITE = 2'd0,
        FK_READ  = 2'd1,
        FK_POLL  = 2'd2
    } t_frame_kind;

    // Frame sequences the back end knows how to play out
    typedef enum logic [3:0] {
        SEQ_READ_FIRST,
        SEQ_PROG_FIRST,
        SEQ_ERASE,
        SEQ_ID,
        SEQ_RSTAT,
        SEQ_WSTAT,
        SEQ_WEN,
        SEQ_READ_CONT,
        SEQ_PROG_CONT
    } t_seq;

    // SPI NOR command bytes
    localparam logic [7:0] CMD_READ     = 8'h03;
    localparam logic [7:0] CMD_PROGRAM  = 8'h02;
    localparam logic [7:0] CMD_ERASE_4K = 8'h20;
    localparam logic [7:0] CMD_RDSR1    = 8'h05;
    localparam logic [7:0] CMD_RDSR2    = 8'h35;
    localparam logic [7:0] CMD_WREN     = 8'h06;
    localparam logic [7:0] CMD_WRDI     = 8'h04;
    localparam logic [7:0] CMD_WRSR     = 8'h01;
    localparam logic [7:0] CMD_READ_ID  = 8'h90;

    localparam int DEF_ADDR_BYTES  = 3;
    localparam int DEF_QUEUE_DEPTH = 4;
    localparam int MAX_FRAMES      = 7;
    localparam int STEP_W          = $clog2(MAX_FRAMES);

    // One classified request waiting for the back end
    typedef struct packed {
        t_seq        seq;
        logic [23:0] address;
        logic [7:0]  data_byte;
        logic [7:0]  data_byte2;
        logic        reg_select;
        logic        final_req;
    } t_job;

    // One SPI frame
    typedef struct packed {
        t_frame_kind frame_kind;
        logic [7:0]  mosi_byte;
        logic        release_select;
        logic        last_frame;
    } t_frame;

endpackage

// File: hdl/snfcs_if.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer channels
// Request channel from the host and frame channel to the serial shifter.
// ----------------------------------------------------------------------------
interface snfcs_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [23:0] address;
    logic [7:0]  data_byte;
    logic [7:0]  data_byte2;
    logic        reg_select;
    logic        first;
    logic        final_req;

    modport source (
        output valid, func, address, data_byte, data_byte2, reg_select, first,
               final_req,
        input  ready
    );
    modport sink (
        input  valid, func, address, data_byte, data_byte2, reg_select, first,
               final_req,
        output ready
    );
endinterface

interface snfcs_frm_if;
    logic       valid;
    logic       ready;
    logic [1:0] frame_kind;
    logic [7:0] mosi_byte;
    logic       release_select;
    logic       last_frame;

    modport source (
        output valid, frame_kind, mosi_byte, release_select, last_frame,
        input  ready
    );
    modport sink (
        input  valid, frame_kind, mosi_byte, release_select, last_frame,
        output ready
    );
endinterface

// File: hdl/snfcs_front.sv
// ----------------------------------------------------------------------------
// Request front end
// Accepts host requests, tracks the open stream and classifies each request
// into a frame sequence for the queue.
// ----------------------------------------------------------------------------
module snfcs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    snfcs_req_if.sink          i_req,
    input  logic               i_full,
    output logic               o_push,
    output snfcs_pkg::t_job    o_job
);
    import snfcs_pkg::*;

    logic r_op_open;
    logic r_op_prog;
    logic n_op_open;
    logic n_op_prog;
    logic accept;
    logic has_frames;
    t_seq seq;

    assign i_req.ready = !i_full;
    assign accept      = i_req.valid && i_req.ready;

    // Classify the request
    always_comb begin
        has_frames = 1'b1;
        seq        = SEQ_WEN;
        n_op_open  = r_op_open;
        n_op_prog  = r_op_prog;
        if (!i_req.first) begin
            has_frames = r_op_open;
            seq        = r_op_prog ? SEQ_PROG_CONT : SEQ_READ_CONT;
            if (i_req.final_req) begin
                n_op_open = 1'b0;
            end
        end else begin
            n_op_open = 1'b0;
            case (t_func'(i_req.func))
                FN_READ: begin
                    seq       = SEQ_READ_FIRST;
                    n_op_open = !i_req.final_req;
                    n_op_prog = 1'b0;
                end
                FN_PROG: begin
                    seq       = SEQ_PROG_FIRST;
                    n_op_open = !i_req.final_req;
                    n_op_prog = 1'b1;
                end
                FN_ERASE: seq = SEQ_ERASE;
                FN_ID:    seq = SEQ_ID;
                FN_RSTAT: seq = SEQ_RSTAT;
                FN_WSTAT: seq = SEQ_WSTAT;
                FN_WEN:   seq = SEQ_WEN;
                default: begin
                    // unused code: no frames, state untouched
                    has_frames = 1'b0;
                    n_op_open  = r_op_open;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_open <= 1'b0;
            r_op_prog <= 1'b0;
        end else if (accept) begin
            r_op_open <= n_op_open;
            r_op_prog <= n_op_prog;
        end
    end

    assign o_push           = accept && has_frames;
    assign o_job.seq        = seq;
    assign o_job.address    = i_req.address;
    assign o_job.data_byte  = i_req.data_byte;
    assign o_job.data_byte2 = i_req.data_byte2;
    assign o_job.reg_select = i_req.reg_select;
    assign o_job.final_req  = i_req.final_req;

endmodule

// File: hdl/snfcs_queue.sv
// ----------------------------------------------------------------------------
// Job queue
// Short first-in first-out store between the front and back ends.
// ----------------------------------------------------------------------------
module snfcs_queue #(
    parameter int DEPTH = snfcs_pkg::DEF_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  snfcs_pkg::t_job    i_job,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output snfcs_pkg::t_job    o_head
);
    import snfcs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: hdl/snfcs_back.sv
// ----------------------------------------------------------------------------
// Frame back end
// Plays out the frames of the job at the queue head, one frame per cycle
// while the shifter accepts them, into a registered output stage.
// ----------------------------------------------------------------------------
module snfcs_back #(
    parameter int ADDR_BYTES = snfcs_pkg::DEF_ADDR_BYTES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  snfcs_pkg::t_job    i_job,
    output logic               o_pop,
    snfcs_frm_if.source        o_frm
);
    import snfcs_pkg::*;

    localparam logic [STEP_W-1:0] ADDR_LEN = (ADDR_BYTES == 4) ? STEP_W'(4) : STEP_W'(3);

    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    t_frame            r_out;

    logic              advance;
    logic              load;
    logic [STEP_W-1:0] last_idx;
    t_frame            frame;

    // Address byte j of the address phase, most significant first
    function automatic logic [7:0] addr_byte(logic [23:0] addr, logic [STEP_W-1:0] j);
        logic [STEP_W-1:0] pos;
        logic [7:0]        b;
        pos = ADDR_LEN - 1'b1 - j;
        case (pos)
            STEP_W'(0): b = addr[7:0];
            STEP_W'(1): b = addr[15:8];
            STEP_W'(2): b = addr[23:16];
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

    // Index of the last frame of the head job
    always_comb begin
        case (i_job.seq)
            SEQ_READ_FIRST: last_idx = ADDR_LEN + STEP_W'(1);
            SEQ_PROG_FIRST: last_idx = (i_job.final_req && ADDR_LEN != STEP_W'(4))
                                       ? ADDR_LEN + STEP_W'(3) : ADDR_LEN + STEP_W'(2);
            SEQ_ERASE:      last_idx = ADDR_LEN + STEP_W'(2);
            SEQ_ID:         last_idx = STEP_W'(5);
            SEQ_RSTAT:      last_idx = STEP_W'(1);
            SEQ_WSTAT:      last_idx = STEP_W'(4);
            SEQ_PROG_CONT:  last_idx = i_job.final_req ? STEP_W'(1) : STEP_W'(0);
            default:        last_idx = STEP_W'(0);
        endcase
    end

    // Frame at the current step
    always_comb begin
        frame.frame_kind     = FK_WRITE;
        frame.mosi_byte      = 8'h00;
        frame.release_select = 1'b0;
        case (i_job.seq)
            SEQ_READ_FIRST: begin
                if (r_step == '0) begin
                    frame.mosi_byte = CMD_READ;
                end else if (r_step <= ADDR_LEN) begin
                    frame.mosi_byte = addr_byte(i_job.address, r_step - STEP_W'(1));
                end else begin
                    frame.frame_kind     = FK_READ;
                    frame.release_select = i_job.final_req;
                end
            end
            SEQ_PROG_FIRST, SEQ_ERASE: begin
                if (r_step == '0) begin
                    frame.mosi_byte      = CMD_WREN;
                    frame.release_select = 1'b1;
                end else if (r_step == STEP_W'(1)) begin
                    frame.mosi_byte = (i_job.seq == SEQ_ERASE) ? CMD_ERASE_4K : CMD_PROGRAM;
                end else if (r_step <= ADDR_LEN + STEP_W'(1)) begin
                    frame.mosi_byte      = addr_byte(i_job.address, r_step - STEP_W'(2));
                    frame.release_select = (i_job.seq == SEQ_ERASE)
                                           && (r_step == ADDR_LEN + STEP_W'(1));
                end else if (i_job.seq == SEQ_PROG_FIRST && r_step == ADDR_LEN + STEP_W'(2)) begin
                    frame.mosi_byte      = i_job.data_byte;
                    frame.release_select = i_job.final_req;
                end else begin
                    frame.frame_kind     = FK_POLL;
                    frame.release_select = 1'b1;
                end
            end
            SEQ_ID: begin
                if (r_step == '0) begin
                    frame.mosi_byte = CMD_READ_ID;
                end else if (r_step >= STEP_W'(4)) begin
                    frame.frame_kind     = FK_READ;
                    frame.release_select = (r_step == STEP_W'(5));
                end
            end
            SEQ_RSTAT: begin
                if (r_step == '0) begin
                    frame.mosi_byte = i_job.reg_select ? CMD_RDSR2 : CMD_RDSR1;
                end else begin
                    frame.frame_kind     = FK_READ;
                    frame.release_select = 1'b1;
                end
            end
            SEQ_WSTAT: begin
                case (r_step)
                    STEP_W'(0): begin
                        frame.mosi_byte      = CMD_WREN;
                        frame.release_select = 1'b1;
                    end
                    STEP_W'(1): frame.mosi_byte = CMD_WRSR;
                    STEP_W'(2): frame.mosi_byte = i_job.data_byte;
                    STEP_W'(3): begin
                        frame.mosi_byte      = i_job.data_byte2;
                        frame.release_select = 1'b1;
                    end
                    default: begin
                        frame.frame_kind     = FK_POLL;
                        frame.release_select = 1'b1;
                    end
                endcase
            end
            SEQ_WEN: begin
                frame.mosi_byte      = i_job.data_byte[0] ? CMD_WREN : CMD_WRDI;
                frame.release_select = 1'b1;
            end
            SEQ_READ_CONT: begin
                frame.frame_kind     = FK_READ;
                frame.release_select = i_job.final_req;
            end
            SEQ_PROG_CONT: begin
                if (r_step == '0) begin
                    frame.mosi_byte      = i_job.data_byte;
                    frame.release_select = i_job.final_req;
                end else begin
                    frame.frame_kind     = FK_POLL;
                    frame.release_select = 1'b1;
                end
            end
            default: begin
                frame.frame_kind = FK_WRITE;
            end
        endcase
        frame.last_frame = (r_step == last_idx);
    end

    assign advance = !r_out_valid || o_frm.ready;
    assign load    = advance && i_valid;
    assign o_pop   = load && frame.last_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= i_valid;
            if (i_valid) begin
                r_step <= frame.last_frame ? '0 : r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= frame;
        end
    end

    assign o_frm.valid          = r_out_valid;
    assign o_frm.frame_kind     = r_out.frame_kind;
    assign o_frm.mosi_byte      = r_out.mosi_byte;
    assign o_frm.release_select = r_out.release_select;
    assign o_frm.last_frame     = r_out.last_frame;

`ifndef NO_ASSERTIONS
    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> r_step <= last_idx)
        else $error("frame step beyond the last frame of the job");

    a_poll_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frm.valid && o_frm.frame_kind == FK_POLL |-> o_frm.release_select)
        else $error("busy poll without chip select release");

    a_step_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_step == '0)
        else $error("step counter not cleared after job completion");

    a_job_ends_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> o_frm.valid && o_frm.last_frame)
        else $error("completed job left without a last frame mark");
`endif

endmodule

// File: hdl/spi_nor_flash_command_sequencer.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer
// Expands host flash requests into SPI byte frames for a serial shifter.
// ----------------------------------------------------------------------------
// Each accepted request is classified combinationally by the front end and
// placed in a short queue; the back end then emits the request's frames at
// one frame per clock, while the shifter is ready, into a registered output
// stage. A request yields one frame for a streamed read or program byte
// (two when a final program byte adds its busy poll) and up to seven for an
// erase or a program opener, so the back end's frame counter sets the rate.
// Requests keep being accepted while the queue has room, so the host side
// runs ahead of a stalled shifter by up to QUEUE_DEPTH requests. Requests
// that produce no frames (a continuation with no stream open, or an unused
// function code) are accepted and consumed in the front end alone.
// ADDR_BYTES selects three or four address bytes; with four, the top byte
// is sent as zero and a single-item program drops its trailing busy poll.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer #(
    parameter int ADDR_BYTES  = snfcs_pkg::DEF_ADDR_BYTES,
    parameter int QUEUE_DEPTH = snfcs_pkg::DEF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    snfcs_req_if.sink   i_req,
    snfcs_frm_if.source o_frm
);
    import snfcs_pkg::*;

    // Front to queue
    logic push;
    logic full;
    t_job push_job;

    // Queue to back end
    logic head_valid;
    logic pop;
    t_job head_job;

    // Classify requests and track the open read or program stream
    snfcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    // Decouple the host side from the shifter side
    snfcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head_job)
    );

    // Play out frames, one per transfer
    snfcs_back #(
        .ADDR_BYTES (ADDR_BYTES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_frm   (o_frm)
    );

endmodule
